### sv/rtttl_melody_parser_assert.svh
// Assertion macros shared by the melody parser RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef RTTTL_MELODY_PARSER_ASSERT_SVH
`define RTTTL_MELODY_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RMP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/rmp_pkg.sv
// Types, character codes and helpers for the melody parser.
// No dependencies; used by rmp_div and rtttl_melody_parser.
`default_nettype none

package rmp_pkg;

    localparam int DIVIDEND_W = 18;
    localparam int DIVISOR_W  = 8;
    localparam int ACC_W      = 10;

    localparam logic [DIVIDEND_W-1:0] BEAT_NUM      = 18'd240000;
    localparam logic [DIVIDEND_W-1:0] BEAT_ALL_ONES = 18'h3FFFF;

    localparam logic [7:0] FB_DURATION_RESET = 8'd4;
    localparam logic [3:0] FB_OCTAVE_RESET   = 4'd6;
    localparam logic [7:0] FB_BPM_RESET      = 8'd63;
    localparam logic [DIVIDEND_W-1:0] BEAT_RESET = DIVIDEND_W'(240000 / 63);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_P_UP  = 8'h50;
    localparam logic [7:0] CH_P_LOW = 8'h70;
    localparam logic [7:0] CH_D_LOW = 8'h64;
    localparam logic [7:0] CH_O_LOW = 8'h6F;
    localparam logic [7:0] CH_B_LOW = 8'h62;

    // Configuration register indexes
    localparam logic [1:0] REG_FB_DURATION = 2'd0;
    localparam logic [1:0] REG_FB_OCTAVE   = 2'd1;
    localparam logic [1:0] REG_FB_BPM      = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BEAT,
        ST_NOTE,
        ST_EMIT,
        ST_END
    } seq_state_t;

    typedef enum logic [1:0] {
        PH_TITLE,
        PH_HEADER,
        PH_NOTES,
        PH_DONE
    } parse_phase_t;

    typedef enum logic [1:0] {
        KEY_NONE,
        KEY_DUR,
        KEY_OCT,
        KEY_BPM
    } header_key_t;

    typedef enum logic [2:0] {
        SUB_START,
        SUB_DUR,
        SUB_LETTER,
        SUB_SHARP,
        SUB_DOT,
        SUB_OCT
    } sub_phase_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    // acc * 10 + digit, kept to the accumulator width
    function automatic logic [ACC_W-1:0] acc_push(input logic [ACC_W-1:0] acc,
                                                  input logic [3:0] digit);
        logic [ACC_W-1:0] x8;
        logic [ACC_W-1:0] x2;
        x8 = {acc[ACC_W-4:0], 3'b000};
        x2 = {acc[ACC_W-2:0], 1'b0};
        return x8 + x2 + {{(ACC_W-4){1'b0}}, digit};
    endfunction

endpackage

`default_nettype wire

### sv/rmp_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on rmp_pkg and rtttl_melody_parser_assert.svh.
`default_nettype none

`include "rtttl_melody_parser_assert.svh"

module rmp_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [rmp_pkg::DIVIDEND_W-1:0] dividend,
    input  wire logic [rmp_pkg::DIVISOR_W-1:0]  divisor,
    output rmp_pkg::div_sts_t                   sts,
    output logic [rmp_pkg::DIVIDEND_W-1:0]      quotient
);

    localparam int DD_W  = rmp_pkg::DIVIDEND_W;
    localparam int DV_W  = rmp_pkg::DIVISOR_W;
    localparam int CNT_W = $clog2(DD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DD_W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DD_W-1:0]  quot_reg, quot_next;
    logic [DV_W-1:0]  rem_reg, rem_next;
    logic [DV_W-1:0]  dvs_reg, dvs_next;

    logic [DV_W:0] trial;
    logic [DV_W:0] diff;
    logic          fits;

    assign trial = {rem_reg, quot_reg[DD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[DD_W-2:0], fits};
            rem_next  = fits ? diff[DV_W-1:0] : trial[DV_W-1:0];
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = quot_reg;

    `RMP_ASSERT_SAME(a_no_restart, start, !busy_reg, "divider started while busy")
    `RMP_ASSERT_NEXT(a_done_single, done_reg, !done_reg && !busy_reg, "done not a single pulse")

endmodule

`default_nettype wire

### sv/rtttl_melody_parser.sv
// Ringtone text parser top level: character parser, sequencer and result register.
// Depends on rmp_pkg, rmp_div and rtttl_melody_parser_assert.svh.
//
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   text_char, song_start
// result    out        out_valid / out_stall note_letter, is_sharp, note_octave,
//                                            length_ms, song_end, run_last
// config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Most characters cause no stall. A character that closes a note, or the b= value
// or the title colon, waits on the shared 18-step divider unless its divisor is zero.
// A closing NUL after a note also sends the end marker after the note's result.
// Reset loads the fallback registers and starts in title skip.
// A stalled result is held in the output register; the next character is taken meanwhile.
`default_nettype none

`include "rtttl_melody_parser_assert.svh"

module rtttl_melody_parser #(
    parameter int MAX_DIGITS   = 3,
    parameter int LENGTH_WIDTH = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [7:0]              text_char,
    input  wire logic                    song_start,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [7:0]                   note_letter,
    output logic                         is_sharp,
    output logic [3:0]                   note_octave,
    output logic [LENGTH_WIDTH-1:0]      length_ms,
    output logic                         song_end,
    output logic                         run_last,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [1:0]              cfg_index,
    input  wire logic [7:0]              cfg_data
);

    localparam int DD_W   = rmp_pkg::DIVIDEND_W;
    localparam int ACC_W  = rmp_pkg::ACC_W;
    localparam int DCNT_W = $clog2(MAX_DIGITS + 1);
    localparam int SUM_W  = DD_W + 1;
    localparam int EXT_W  = (LENGTH_WIDTH > SUM_W) ? LENGTH_WIDTH : SUM_W;
    localparam logic [EXT_W-1:0] LMAX = EXT_W'((64'd1 << LENGTH_WIDTH) - 64'd1);
    localparam logic [DCNT_W-1:0] DCNT_MAX = DCNT_W'(MAX_DIGITS);

    // configuration
    logic [7:0] fb_dur_reg;
    logic [3:0] fb_oct_reg;
    logic [7:0] fb_bpm_reg;

    // sequencer and parser state
    rmp_pkg::seq_state_t   state_reg, state_next;
    rmp_pkg::parse_phase_t phase_reg, phase_next;
    rmp_pkg::header_key_t  key_reg, key_next;
    rmp_pkg::sub_phase_t   sub_reg, sub_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [DCNT_W-1:0]     dcnt_reg, dcnt_next;
    logic [7:0]            def_div_reg, def_div_next;
    logic [3:0]            def_oct_reg, def_oct_next;
    logic [DD_W-1:0]       beat_reg, beat_next;
    logic [7:0]            p_letter_reg, p_letter_next;
    logic                  p_sharp_reg, p_sharp_next;
    logic                  p_dot_reg, p_dot_next;
    logic [3:0]            p_oct_reg, p_oct_next;
    logic [7:0]            p_div_reg, p_div_next;
    logic                  p_pend_reg, p_pend_next;

    // note being emitted
    logic [7:0] e_letter_reg, e_letter_next;
    logic       e_sharp_reg, e_sharp_next;
    logic [3:0] e_oct_reg, e_oct_next;
    logic       e_dot_reg, e_dot_next;
    logic       e_zero_reg, e_zero_next;
    logic       end_pend_reg, end_pend_next;

    // result register
    logic                    out_valid_reg, out_valid_next;
    logic [7:0]              o_letter_reg, o_letter_next;
    logic                    o_sharp_reg, o_sharp_next;
    logic [3:0]              o_oct_reg, o_oct_next;
    logic [LENGTH_WIDTH-1:0] o_len_reg, o_len_next;
    logic                    o_end_reg, o_end_next;
    logic                    o_last_reg, o_last_next;

    // divider
    logic                 div_start;
    logic [DD_W-1:0]      div_dividend;
    logic [7:0]           div_divisor;
    rmp_pkg::div_sts_t    div_sts;
    logic [DD_W-1:0]      div_quot;

    logic accept;
    logic out_free;
    logic [SUM_W-1:0] len_sum;
    logic [SUM_W-1:0] len_raw;
    logic [EXT_W-1:0] len_ext;
    logic [LENGTH_WIDTH-1:0] len_final;

    rmp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .sts      (div_sts),
        .quotient (div_quot)
    );

    assign in_stall  = (state_reg != rmp_pkg::ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    // length = quotient, plus half of it when dotted, saturated
    assign len_sum   = {1'b0, div_quot} + {2'b00, div_quot[DD_W-1:1]};
    assign len_raw   = e_dot_reg ? len_sum : {1'b0, div_quot};
    assign len_ext   = EXT_W'(len_raw);
    assign len_final = (e_zero_reg || (len_ext > LMAX)) ? LMAX[LENGTH_WIDTH-1:0]
                                                        : len_ext[LENGTH_WIDTH-1:0];

    always_comb
    begin
        logic       emit;
        logic       endm;
        logic       beat_go;
        logic [7:0] beat_dvs;
        logic       cont;
        logic [7:0] c;

        state_next    = state_reg;
        phase_next    = phase_reg;
        key_next      = key_reg;
        sub_next      = sub_reg;
        acc_next      = acc_reg;
        dcnt_next     = dcnt_reg;
        def_div_next  = def_div_reg;
        def_oct_next  = def_oct_reg;
        beat_next     = beat_reg;
        p_letter_next = p_letter_reg;
        p_sharp_next  = p_sharp_reg;
        p_dot_next    = p_dot_reg;
        p_oct_next    = p_oct_reg;
        p_div_next    = p_div_reg;
        p_pend_next   = p_pend_reg;
        e_letter_next = e_letter_reg;
        e_sharp_next  = e_sharp_reg;
        e_oct_next    = e_oct_reg;
        e_dot_next    = e_dot_reg;
        e_zero_next   = e_zero_reg;
        end_pend_next = end_pend_reg;

        out_valid_next = out_valid_reg && out_stall;
        o_letter_next  = o_letter_reg;
        o_sharp_next   = o_sharp_reg;
        o_oct_next     = o_oct_reg;
        o_len_next     = o_len_reg;
        o_end_next     = o_end_reg;
        o_last_next    = o_last_reg;

        div_start    = 1'b0;
        div_dividend = beat_reg;
        div_divisor  = p_div_reg;

        emit     = 1'b0;
        endm     = 1'b0;
        beat_go  = 1'b0;
        beat_dvs = fb_bpm_reg;
        cont     = 1'b1;
        c        = text_char;

        case (state_reg)
            rmp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (song_start)
                    begin
                        phase_next    = rmp_pkg::PH_TITLE;
                        key_next      = rmp_pkg::KEY_NONE;
                        sub_next      = rmp_pkg::SUB_START;
                        p_letter_next = '0;
                        p_sharp_next  = 1'b0;
                        p_dot_next    = 1'b0;
                        p_oct_next    = '0;
                        p_div_next    = '0;
                        p_pend_next   = 1'b0;
                        acc_next      = '0;
                        dcnt_next     = '0;
                    end

                    if (phase_next == rmp_pkg::PH_DONE)
                    begin
                        // drop everything until the next song start
                    end
                    else if (c == rmp_pkg::CH_NUL)
                    begin
                        emit          = (phase_next == rmp_pkg::PH_NOTES) && p_pend_next;
                        endm          = 1'b1;
                        phase_next    = rmp_pkg::PH_DONE;
                        sub_next      = rmp_pkg::SUB_START;
                        p_letter_next = '0;
                        p_sharp_next  = 1'b0;
                        p_dot_next    = 1'b0;
                        p_oct_next    = '0;
                        p_div_next    = '0;
                        p_pend_next   = 1'b0;
                        acc_next      = '0;
                        dcnt_next     = '0;
                    end
                    else if (phase_next == rmp_pkg::PH_TITLE)
                    begin
                        if (c == rmp_pkg::CH_COLON)
                        begin
                            phase_next   = rmp_pkg::PH_HEADER;
                            key_next     = rmp_pkg::KEY_NONE;
                            acc_next     = '0;
                            dcnt_next    = '0;
                            def_div_next = fb_dur_reg;
                            def_oct_next = fb_oct_reg;
                            beat_go      = 1'b1;
                            beat_dvs     = fb_bpm_reg;
                        end
                    end
                    else if (phase_next == rmp_pkg::PH_HEADER)
                    begin
                        if (c == rmp_pkg::CH_COMMA || c == rmp_pkg::CH_COLON)
                        begin
                            case (key_next)
                                rmp_pkg::KEY_DUR: def_div_next = acc_next[7:0];
                                rmp_pkg::KEY_OCT: def_oct_next = acc_next[3:0];
                                rmp_pkg::KEY_BPM:
                                begin
                                    beat_go  = 1'b1;
                                    beat_dvs = acc_next[7:0];
                                end
                                default: ;
                            endcase
                            key_next  = rmp_pkg::KEY_NONE;
                            acc_next  = '0;
                            dcnt_next = '0;
                            if (c == rmp_pkg::CH_COLON)
                            begin
                                phase_next    = rmp_pkg::PH_NOTES;
                                sub_next      = rmp_pkg::SUB_START;
                                p_letter_next = '0;
                                p_sharp_next  = 1'b0;
                                p_dot_next    = 1'b0;
                                p_oct_next    = '0;
                                p_div_next    = '0;
                                p_pend_next   = 1'b0;
                            end
                        end
                        else if (key_next == rmp_pkg::KEY_NONE)
                        begin
                            if (c == rmp_pkg::CH_D_LOW)
                                key_next = rmp_pkg::KEY_DUR;
                            else if (c == rmp_pkg::CH_O_LOW)
                                key_next = rmp_pkg::KEY_OCT;
                            else if (c == rmp_pkg::CH_B_LOW)
                                key_next = rmp_pkg::KEY_BPM;
                            acc_next  = '0;
                            dcnt_next = '0;
                        end
                        else if (rmp_pkg::is_digit(c) && (dcnt_next < DCNT_MAX))
                        begin
                            acc_next  = rmp_pkg::acc_push(acc_next, c[3:0]);
                            dcnt_next = dcnt_next + 1'b1;
                        end
                    end
                    else
                    begin
                        // note phase: modifiers after the letter, else close the note
                        if (sub_next == rmp_pkg::SUB_LETTER || sub_next == rmp_pkg::SUB_SHARP ||
                            sub_next == rmp_pkg::SUB_DOT || sub_next == rmp_pkg::SUB_OCT)
                        begin
                            if (c == rmp_pkg::CH_HASH && sub_next == rmp_pkg::SUB_LETTER)
                            begin
                                p_sharp_next = 1'b1;
                                sub_next     = rmp_pkg::SUB_SHARP;
                                cont         = 1'b0;
                            end
                            else if (c == rmp_pkg::CH_DOT && (sub_next == rmp_pkg::SUB_LETTER ||
                                     sub_next == rmp_pkg::SUB_SHARP))
                            begin
                                p_dot_next = 1'b1;
                                sub_next   = rmp_pkg::SUB_DOT;
                                cont       = 1'b0;
                            end
                            else if (rmp_pkg::is_digit(c) && sub_next != rmp_pkg::SUB_OCT)
                            begin
                                p_oct_next = c[3:0];
                                sub_next   = rmp_pkg::SUB_OCT;
                                cont       = 1'b0;
                            end
                            else
                            begin
                                emit        = 1'b1;
                                p_pend_next = 1'b0;
                                sub_next    = rmp_pkg::SUB_START;
                                if (c == rmp_pkg::CH_COMMA)
                                    cont = 1'b0;
                            end
                        end

                        if (cont)
                        begin
                            if (sub_next == rmp_pkg::SUB_DUR && !rmp_pkg::is_alpha(c))
                            begin
                                if (rmp_pkg::is_digit(c) && (dcnt_next < DCNT_MAX))
                                begin
                                    acc_next  = rmp_pkg::acc_push(acc_next, c[3:0]);
                                    dcnt_next = dcnt_next + 1'b1;
                                end
                            end
                            else if (sub_next == rmp_pkg::SUB_START && rmp_pkg::is_digit(c))
                            begin
                                acc_next  = {{(ACC_W-4){1'b0}}, c[3:0]};
                                dcnt_next = DCNT_W'(1);
                                sub_next  = rmp_pkg::SUB_DUR;
                            end
                            else
                            begin
                                p_div_next    = (dcnt_next != '0) ? acc_next[7:0] : def_div_reg;
                                p_letter_next = c;
                                p_sharp_next  = 1'b0;
                                p_dot_next    = 1'b0;
                                p_oct_next    = def_oct_reg;
                                p_pend_next   = 1'b1;
                                sub_next      = rmp_pkg::SUB_LETTER;
                                acc_next      = '0;
                                dcnt_next     = '0;
                            end
                        end
                    end

                    if (beat_go)
                    begin
                        if (beat_dvs == '0)
                            beat_next = rmp_pkg::BEAT_ALL_ONES;
                        else
                        begin
                            div_start    = 1'b1;
                            div_dividend = rmp_pkg::BEAT_NUM;
                            div_divisor  = beat_dvs;
                            state_next   = rmp_pkg::ST_BEAT;
                        end
                    end
                    else if (emit)
                    begin
                        // latch the closing note; a pause drops letter, sharp and octave
                        if (p_letter_reg == rmp_pkg::CH_P_UP || p_letter_reg == rmp_pkg::CH_P_LOW)
                        begin
                            e_letter_next = '0;
                            e_sharp_next  = 1'b0;
                            e_oct_next    = '0;
                        end
                        else
                        begin
                            e_letter_next = p_letter_reg;
                            e_sharp_next  = p_sharp_reg;
                            e_oct_next    = p_oct_reg;
                        end
                        e_dot_next    = p_dot_reg;
                        e_zero_next   = (p_div_reg == '0);
                        end_pend_next = endm;
                        if (p_div_reg == '0)
                            state_next = rmp_pkg::ST_EMIT;
                        else
                        begin
                            div_start    = 1'b1;
                            div_dividend = beat_reg;
                            div_divisor  = p_div_reg;
                            state_next   = rmp_pkg::ST_NOTE;
                        end
                    end
                    else if (endm)
                        state_next = rmp_pkg::ST_END;
                end
            end

            rmp_pkg::ST_BEAT:
            begin
                if (div_sts.done)
                begin
                    beat_next  = div_quot;
                    state_next = rmp_pkg::ST_IDLE;
                end
            end

            rmp_pkg::ST_NOTE:
            begin
                if (div_sts.done)
                    state_next = rmp_pkg::ST_EMIT;
            end

            rmp_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_letter_next  = e_letter_reg;
                    o_sharp_next   = e_sharp_reg;
                    o_oct_next     = e_oct_reg;
                    o_len_next     = len_final;
                    o_end_next     = 1'b0;
                    o_last_next    = !end_pend_reg;
                    state_next     = end_pend_reg ? rmp_pkg::ST_END : rmp_pkg::ST_IDLE;
                end
            end

            rmp_pkg::ST_END:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_letter_next  = '0;
                    o_sharp_next   = 1'b0;
                    o_oct_next     = '0;
                    o_len_next     = '0;
                    o_end_next     = 1'b1;
                    o_last_next    = 1'b1;
                    end_pend_next  = 1'b0;
                    state_next     = rmp_pkg::ST_IDLE;
                end
            end

            default:
                state_next = rmp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_dur_reg <= rmp_pkg::FB_DURATION_RESET;
            fb_oct_reg <= rmp_pkg::FB_OCTAVE_RESET;
            fb_bpm_reg <= rmp_pkg::FB_BPM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rmp_pkg::REG_FB_DURATION: fb_dur_reg <= cfg_data;
                rmp_pkg::REG_FB_OCTAVE:   fb_oct_reg <= cfg_data[3:0];
                rmp_pkg::REG_FB_BPM:      fb_bpm_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rmp_pkg::ST_IDLE;
            phase_reg     <= rmp_pkg::PH_TITLE;
            key_reg       <= rmp_pkg::KEY_NONE;
            sub_reg       <= rmp_pkg::SUB_START;
            acc_reg       <= '0;
            dcnt_reg      <= '0;
            def_div_reg   <= rmp_pkg::FB_DURATION_RESET;
            def_oct_reg   <= rmp_pkg::FB_OCTAVE_RESET;
            beat_reg      <= rmp_pkg::BEAT_RESET;
            p_letter_reg  <= '0;
            p_sharp_reg   <= 1'b0;
            p_dot_reg     <= 1'b0;
            p_oct_reg     <= '0;
            p_div_reg     <= '0;
            p_pend_reg    <= 1'b0;
            end_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            key_reg       <= key_next;
            sub_reg       <= sub_next;
            acc_reg       <= acc_next;
            dcnt_reg      <= dcnt_next;
            def_div_reg   <= def_div_next;
            def_oct_reg   <= def_oct_next;
            beat_reg      <= beat_next;
            p_letter_reg  <= p_letter_next;
            p_sharp_reg   <= p_sharp_next;
            p_dot_reg     <= p_dot_next;
            p_oct_reg     <= p_oct_next;
            p_div_reg     <= p_div_next;
            p_pend_reg    <= p_pend_next;
            end_pend_reg  <= end_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_letter_reg <= e_letter_next;
        e_sharp_reg  <= e_sharp_next;
        e_oct_reg    <= e_oct_next;
        e_dot_reg    <= e_dot_next;
        e_zero_reg   <= e_zero_next;
        o_letter_reg <= o_letter_next;
        o_sharp_reg  <= o_sharp_next;
        o_oct_reg    <= o_oct_next;
        o_len_reg    <= o_len_next;
        o_end_reg    <= o_end_next;
        o_last_reg   <= o_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign note_letter = o_letter_reg;
    assign is_sharp    = o_sharp_reg;
    assign note_octave = o_oct_reg;
    assign length_ms   = o_len_reg;
    assign song_end    = o_end_reg;
    assign run_last    = o_last_reg;

    `RMP_ASSERT_SAME(a_stall_while_div, div_sts.busy, in_stall, "input taken while divider busy")
    `RMP_ASSERT_SAME(a_end_is_last, out_valid && song_end, run_last, "end marker not last")
    `RMP_ASSERT_SAME(a_done_in_wait, div_sts.done,
        state_reg == rmp_pkg::ST_BEAT || state_reg == rmp_pkg::ST_NOTE,
        "divider result with no sequencer waiting")
    `RMP_ASSERT_NEXT(a_end_follows_note,
        state_reg == rmp_pkg::ST_EMIT && out_free && end_pend_reg,
        state_reg == rmp_pkg::ST_END, "end marker lost after final note")

endmodule

`default_nettype wire

### dv/rtttl_melody_parser_checker.sv
// Result checker for the ringtone text parser: watches the text, result and register
// channels, works out the notes each accepted character yields and compares them in order.
// Depends on rmp_pkg for the phase, key and sub-phase types and the character codes.
`timescale 1ns / 1ps

module rtttl_melody_parser_checker #(
    parameter int MAX_DIGITS   = 3,
    parameter int LENGTH_WIDTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [7:0]              text_char,
    input  logic                    song_start,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic [7:0]              note_letter,
    input  logic                    is_sharp,
    input  logic [3:0]              note_octave,
    input  logic [LENGTH_WIDTH-1:0] length_ms,
    input  logic                    song_end,
    input  logic                    run_last,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [7:0]              cfg_data,
    output int                      failures,
    output int                      pending_results
);

    localparam int          ACC_W    = rmp_pkg::ACC_W;
    localparam int          DD_W     = rmp_pkg::DIVIDEND_W;
    localparam int unsigned LEN_MAX  = (32'd1 << LENGTH_WIDTH) - 1;
    localparam logic [7:0]  CH_ZERO  = "0";
    localparam int          SHOW_MAX = 10;

    typedef struct packed {
        logic [7:0]              letter;
        logic                    sharp;
        logic [3:0]              octave;
        logic [LENGTH_WIDTH-1:0] len;
        logic                    end_mark;
        logic                    last;
    } tone_t;

    tone_t tones_due[$];
    tone_t step_tones[$];
    tone_t seen;
    tone_t due;
    int    shown;

    // fallback registers
    logic [7:0] fb_duration;
    logic [3:0] fb_octave;
    logic [7:0] fb_bpm;

    // parser state
    rmp_pkg::parse_phase_t  phase;
    rmp_pkg::header_key_t   key;
    logic [ACC_W-1:0]       num;
    logic [1:0]             ndigits;
    logic [7:0]             def_div;
    logic [3:0]             def_oct;
    logic [DD_W-1:0]        beat_ms;
    rmp_pkg::sub_phase_t    sub;
    logic [7:0]             pend_letter;
    logic                   pend_sharp;
    logic                   pend_dot;
    logic [3:0]             pend_oct;
    logic [7:0]             pend_div;
    logic                   note_open;

    function automatic logic digit_char(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic letter_char(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic [DD_W-1:0] beat_for(input logic [7:0] bpm);
        return (bpm == 8'd0) ? rmp_pkg::BEAT_ALL_ONES : rmp_pkg::BEAT_NUM / bpm;
    endfunction

    task automatic take_digit(input logic [7:0] c);
        if (ndigits < MAX_DIGITS)
        begin
            num = ACC_W'(num * 10 + (c - CH_ZERO));
            ndigits = ndigits + 2'd1;
        end
    endtask

    task automatic add_tone(input logic [7:0] letter, input logic sharp,
                            input logic [3:0] oct, input logic [LENGTH_WIDTH-1:0] len,
                            input logic end_mark);
        tone_t t;
        t.letter   = letter;
        t.sharp    = sharp;
        t.octave   = oct;
        t.len      = len;
        t.end_mark = end_mark;
        t.last     = 1'b0;
        step_tones.push_back(t);
    endtask

    task automatic clear_note();
        sub         = rmp_pkg::SUB_START;
        pend_letter = 8'd0;
        pend_sharp  = 1'b0;
        pend_dot    = 1'b0;
        pend_oct    = 4'd0;
        pend_div    = 8'd0;
        note_open   = 1'b0;
        num         = '0;
        ndigits     = 2'd0;
    endtask

    task automatic close_note();
        int unsigned span;
        if (pend_div == 8'd0)
            span = LEN_MAX;
        else
        begin
            span = beat_ms / pend_div;
            // a dot lengthens by half
            if (pend_dot)
                span = span + (span >> 1);
            if (span > LEN_MAX)
                span = LEN_MAX;
        end
        if (pend_letter == rmp_pkg::CH_P_UP || pend_letter == rmp_pkg::CH_P_LOW)
            add_tone(rmp_pkg::CH_NUL, 1'b0, 4'd0, LENGTH_WIDTH'(span), 1'b0);
        else
            add_tone(pend_letter, pend_sharp, pend_oct, LENGTH_WIDTH'(span), 1'b0);
        note_open = 1'b0;
        sub = rmp_pkg::SUB_START;
    endtask

    task automatic read_char(input logic [7:0] c, input logic start);
        if (start)
        begin
            phase = rmp_pkg::PH_TITLE;
            key = rmp_pkg::KEY_NONE;
            clear_note();
        end
        if (phase == rmp_pkg::PH_DONE)
            return;

        if (c == rmp_pkg::CH_NUL)
        begin
            if (phase == rmp_pkg::PH_NOTES && note_open)
                close_note();
            add_tone(rmp_pkg::CH_NUL, 1'b0, 4'd0, '0, 1'b1);
            phase = rmp_pkg::PH_DONE;
            clear_note();
            return;
        end

        if (phase == rmp_pkg::PH_TITLE)
        begin
            if (c == rmp_pkg::CH_COLON)
            begin
                phase   = rmp_pkg::PH_HEADER;
                key     = rmp_pkg::KEY_NONE;
                num     = '0;
                ndigits = 2'd0;
                def_div = fb_duration;
                def_oct = fb_octave;
                beat_ms = beat_for(fb_bpm);
            end
            return;
        end

        if (phase == rmp_pkg::PH_HEADER)
        begin
            if (c == rmp_pkg::CH_COMMA || c == rmp_pkg::CH_COLON)
            begin
                case (key)
                    rmp_pkg::KEY_DUR: def_div = num[7:0];
                    rmp_pkg::KEY_OCT: def_oct = num[3:0];
                    rmp_pkg::KEY_BPM: beat_ms = beat_for(num[7:0]);
                    default: ;
                endcase
                key = rmp_pkg::KEY_NONE;
                num = '0;
                ndigits = 2'd0;
                if (c == rmp_pkg::CH_COLON)
                begin
                    phase = rmp_pkg::PH_NOTES;
                    clear_note();
                end
            end
            else if (key == rmp_pkg::KEY_NONE)
            begin
                if (c == rmp_pkg::CH_D_LOW)
                    key = rmp_pkg::KEY_DUR;
                else if (c == rmp_pkg::CH_O_LOW)
                    key = rmp_pkg::KEY_OCT;
                else if (c == rmp_pkg::CH_B_LOW)
                    key = rmp_pkg::KEY_BPM;
                num = '0;
                ndigits = 2'd0;
            end
            else if (digit_char(c))
                take_digit(c);
            return;
        end

        // notes
        if (sub >= rmp_pkg::SUB_LETTER)
        begin
            if (c == rmp_pkg::CH_HASH && sub == rmp_pkg::SUB_LETTER)
            begin
                pend_sharp = 1'b1;
                sub = rmp_pkg::SUB_SHARP;
                return;
            end
            if (c == rmp_pkg::CH_DOT && sub <= rmp_pkg::SUB_SHARP)
            begin
                pend_dot = 1'b1;
                sub = rmp_pkg::SUB_DOT;
                return;
            end
            if (digit_char(c) && sub <= rmp_pkg::SUB_DOT)
            begin
                pend_oct = 4'(c - CH_ZERO);
                sub = rmp_pkg::SUB_OCT;
                return;
            end
            close_note();
            if (c == rmp_pkg::CH_COMMA)
                return;
            // anything else opens the next note straight away
        end

        if (sub == rmp_pkg::SUB_DUR && !letter_char(c))
        begin
            if (digit_char(c))
                take_digit(c);
        end
        else if (sub == rmp_pkg::SUB_START && digit_char(c))
        begin
            num = '0;
            ndigits = 2'd0;
            take_digit(c);
            sub = rmp_pkg::SUB_DUR;
        end
        else
        begin
            pend_div    = (ndigits != 2'd0) ? num[7:0] : def_div;
            pend_letter = c;
            pend_sharp  = 1'b0;
            pend_dot    = 1'b0;
            pend_oct    = def_oct;
            note_open   = 1'b1;
            sub         = rmp_pkg::SUB_LETTER;
            num         = '0;
            ndigits     = 2'd0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tones_due.delete();
            failures        = 0;
            shown           = 0;
            pending_results <= 0;
            fb_duration     = rmp_pkg::FB_DURATION_RESET;
            fb_octave       = rmp_pkg::FB_OCTAVE_RESET;
            fb_bpm          = rmp_pkg::FB_BPM_RESET;
            phase           = rmp_pkg::PH_TITLE;
            key             = rmp_pkg::KEY_NONE;
            def_div         = rmp_pkg::FB_DURATION_RESET;
            def_oct         = rmp_pkg::FB_OCTAVE_RESET;
            beat_ms         = rmp_pkg::BEAT_RESET;
            clear_note();
        end
        else
        begin
            // compare first: a result never belongs to a character taken at the same edge
            if (out_valid && !out_stall)
            begin
                seen.letter   = note_letter;
                seen.sharp    = is_sharp;
                seen.octave   = note_octave;
                seen.len      = length_ms;
                seen.end_mark = song_end;
                seen.last     = run_last;
                if (tones_due.size() == 0)
                begin
                    failures++;
                    if (shown < SHOW_MAX)
                    begin
                        shown++;
                        $display({"unexpected result transaction: letter=%h sharp=%b",
                                  " oct=%0d len=%0d end=%b last=%b"},
                                 seen.letter, seen.sharp, seen.octave, seen.len,
                                 seen.end_mark, seen.last);
                    end
                end
                else
                begin
                    due = tones_due.pop_front();
                    if (seen.letter !== due.letter || seen.sharp !== due.sharp ||
                        seen.octave !== due.octave || seen.len !== due.len ||
                        seen.end_mark !== due.end_mark || seen.last !== due.last)
                    begin
                        failures++;
                        if (shown < SHOW_MAX)
                        begin
                            shown++;
                            $display({"result mismatch at %0t: expected letter=%h sharp=%b",
                                      " oct=%0d len=%0d end=%b last=%b"},
                                     $realtime, due.letter, due.sharp, due.octave, due.len,
                                     due.end_mark, due.last);
                            $display({"                      got letter=%h sharp=%b",
                                      " oct=%0d len=%0d end=%b last=%b"},
                                     seen.letter, seen.sharp, seen.octave, seen.len,
                                     seen.end_mark, seen.last);
                        end
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rmp_pkg::REG_FB_DURATION: fb_duration = cfg_data;
                    rmp_pkg::REG_FB_OCTAVE:   fb_octave   = cfg_data[3:0];
                    rmp_pkg::REG_FB_BPM:      fb_bpm      = cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                step_tones.delete();
                read_char(text_char, song_start);
                if (step_tones.size() != 0)
                begin
                    due = step_tones.pop_back();
                    due.last = 1'b1;
                    step_tones.push_back(due);
                end
                foreach (step_tones[i])
                    tones_due.push_back(step_tones[i]);
            end

            pending_results <= tones_due.size();
        end
    end

endmodule

### dv/rtttl_melody_parser_test.sv
// Testbench top for the ringtone text parser: drives songs, register writes and stalls,
// and gives the verdict from the failure count of rtttl_melody_parser_checker.
// Depends on rmp_pkg, rtttl_melody_parser and rtttl_melody_parser_checker.
`timescale 1ns / 1ps

module rtttl_melody_parser_test;

    localparam int LENGTH_WIDTH  = 16;
    localparam int SETTLE_CYCLES = 48;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 125;
    localparam logic [7:0] CH_EQUALS = "=";

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [7:0]              text_char = 8'd0;
    logic                    song_start = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [7:0]              note_letter;
    logic                    is_sharp;
    logic [3:0]              note_octave;
    logic [LENGTH_WIDTH-1:0] length_ms;
    logic                    song_end;
    logic                    run_last;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [1:0]              cfg_index = rmp_pkg::REG_FB_DURATION;
    logic [7:0]              cfg_data = 8'd0;

    int         failures;
    int         pending_results;
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    int         chars_sent = 0;
    int         cycle_count = 0;
    logic [7:0] song_chars[$];

    rtttl_melody_parser #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .text_char   (text_char),
        .song_start  (song_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .note_letter (note_letter),
        .is_sharp    (is_sharp),
        .note_octave (note_octave),
        .length_ms   (length_ms),
        .song_end    (song_end),
        .run_last    (run_last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    rtttl_melody_parser_checker #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) melody_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .text_char       (text_char),
        .song_start      (song_start),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .note_letter     (note_letter),
        .is_sharp        (is_sharp),
        .note_octave     (note_octave),
        .length_ms       (length_ms),
        .song_end        (song_end),
        .run_last        (run_last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .failures        (failures),
        .pending_results (pending_results)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    task automatic push_digits(input int count);
        repeat (count)
            song_chars.push_back(8'("0" + $urandom_range(9)));
    endtask

    task automatic send_char(input logic [7:0] c, input logic start);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        text_char  <= c;
        song_start <= start;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_text(input string s, input logic fresh);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], fresh && i == 0);
    endtask

    // hold the sender until every expected result is out, then let the divider finish
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    initial
    begin
        int         phase;
        int         goal;
        int         n;
        logic       noisy;
        logic [7:0] c;
        logic [7:0] dur;
        logic [7:0] bpm;
        logic [3:0] oct;

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero bpm, sharp dotted note with explicit octave, then a new song drops the 'e'
        send_text(":b=0:c#.9,e", 1'b1);
        // digit overflow in header and duration, octave beyond 9, dotted pause,
        // odd char after a letter, NUL closing a note
        send_text("x:d=1000,o=15:1234P.,gz", 1'b1);
        send_char(rmp_pkg::CH_NUL, 1'b0);

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    dur = 8'd1;
                    oct = 4'd0;
                    bpm = 8'd1;
                end
                1:
                begin
                    dur = 8'd255;
                    oct = 4'd9;
                    bpm = 8'd255;
                end
                default:
                begin
                    dur = 8'($urandom_range(255, 1));
                    oct = 4'($urandom_range(9));
                    bpm = 8'($urandom_range(255, 1));
                end
            endcase
            write_reg(rmp_pkg::REG_FB_DURATION, dur);
            write_reg(rmp_pkg::REG_FB_OCTAVE, {4'd0, oct});
            write_reg(rmp_pkg::REG_FB_BPM, bpm);
            cfg_valid <= 1'b0;

            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 58;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 58;
                end
                default:
                begin
                    send_idle_pct = 28;
                    stall_pct = 28;
                end
            endcase

            goal = chars_sent + PHASE_ITEMS;
            while (chars_sent < goal)
            begin
                song_chars.delete();
                noisy = ($urandom_range(99) < 15);
                if (noisy)
                begin
                    n = $urandom_range(20, 5);
                    repeat (n)
                        song_chars.push_back(($urandom_range(19) == 0) ? rmp_pkg::CH_NUL
                                             : 8'($urandom_range(255, 1)));
                end
                else
                begin
                    // title
                    n = $urandom_range(6);
                    repeat (n)
                    begin
                        c = 8'($urandom_range(255, 1));
                        song_chars.push_back((c == rmp_pkg::CH_COLON) ? pick("tune") : c);
                    end
                    song_chars.push_back(rmp_pkg::CH_COLON);
                    // header settings
                    n = $urandom_range(3);
                    for (int i = 0; i < n; i++)
                    begin
                        if (i != 0)
                            song_chars.push_back(rmp_pkg::CH_COMMA);
                        song_chars.push_back(pick("dobdob x"));
                        if ($urandom_range(9) != 0)
                            song_chars.push_back(CH_EQUALS);
                        push_digits($urandom_range(4));
                    end
                    song_chars.push_back(rmp_pkg::CH_COLON);
                    // notes
                    n = $urandom_range(8, 1);
                    for (int i = 0; i < n; i++)
                    begin
                        if ($urandom_range(9) < 4)
                        begin
                            push_digits(($urandom_range(9) == 0) ? 4 : $urandom_range(3, 1));
                            if ($urandom_range(9) == 0)
                                song_chars.push_back(pick(" -_#"));
                        end
                        song_chars.push_back(($urandom_range(19) == 0) ? pick(" ,#.-*")
                                             : pick("cdefgabhCDEFGABPp"));
                        if ($urandom_range(9) < 3)
                            song_chars.push_back(rmp_pkg::CH_HASH);
                        if ($urandom_range(3) == 0)
                            song_chars.push_back(rmp_pkg::CH_DOT);
                        if ($urandom_range(9) < 4)
                            push_digits(1);
                        if (i != n - 1 && $urandom_range(9) != 0)
                            song_chars.push_back(rmp_pkg::CH_COMMA);
                    end
                    if ($urandom_range(9) != 0)
                        song_chars.push_back(rmp_pkg::CH_NUL);
                    // trailing chars after the end are dropped by the block
                    if ($urandom_range(9) == 0)
                        push_digits(2);
                    foreach (song_chars[i])
                        if ($urandom_range(99) < 3)
                            song_chars[i] = 8'($urandom_range(255));
                end
                foreach (song_chars[i])
                    send_char(song_chars[i], (i == 0) || (noisy && $urandom_range(19) == 0));
            end
        end

        drain();
        if (failures == 0 && pending_results == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/rmp_pkg.sv
sv/rmp_div.sv
sv/rtttl_melody_parser.sv
dv/rtttl_melody_parser_checker.sv
dv/rtttl_melody_parser_test.sv
